// ===== hw/rtl/obbo_pkg.sv =====
// ----------------------------------------------------------------------------
// obbo_pkg
// Shared types and sizes for the market-by-order book.
// ----------------------------------------------------------------------------
`default_nettype none

package obbo_pkg;

   localparam int ORDER_SLOTS = 1024;
   localparam int LEVEL_SLOTS = 512;
   localparam int ORDER_AW    = $clog2(ORDER_SLOTS);
   localparam int LEVEL_AW    = $clog2(LEVEL_SLOTS);
   localparam int CLEAR_LEN   = (ORDER_SLOTS > LEVEL_SLOTS) ? ORDER_SLOTS : LEVEL_SLOTS;
   localparam int CNT_W       = $clog2(CLEAR_LEN) + 1;

   localparam int ID_W    = 32;
   localparam int PX_W    = 32;
   localparam int QTY_W   = 32;
   localparam int COUNT_W = 11;

   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 152;

   typedef enum logic [1:0] {
      KIND_ADD    = 2'd0,
      KIND_MODIFY = 2'd1,
      KIND_CANCEL = 2'd2,
      KIND_TRADE  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STAT_APPLIED   = 2'd0,
      STAT_UNKNOWN   = 2'd1,
      STAT_DUPLICATE = 2'd2,
      STAT_FULL      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_OSCAN,
      ST_LSCAN,
      ST_APPLY,
      ST_RSCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic             valid;
      logic             sell;
      logic [ID_W-1:0]  key;
      logic [PX_W-1:0]  price;
      logic [QTY_W-1:0] remaining;
   } order_entry_type;

   typedef struct packed {
      logic               valid;
      logic               sell;
      logic [PX_W-1:0]    price;
      logic [QTY_W-1:0]   total;
      logic [COUNT_W-1:0] count;
   } level_entry_type;

   localparam int ORDER_W = $bits(order_entry_type);
   localparam int LEVEL_W = $bits(level_entry_type);

endpackage

`default_nettype wire

// ===== hw/rtl/order_book_by_order_top.sv =====
// ----------------------------------------------------------------------------
// order_book_by_order_top
// Market-by-order limit order book: add / modify / cancel / trade messages,
// one result transfer per message with status and best bid / best ask.
// ----------------------------------------------------------------------------
// Sequence: an applied message runs the order scan, level scan, apply step and
//   best-level rescan; duplicate, unknown id or full order table stop after the
//   order scan; an add with a full level table stops after the level scan.
// Throughput: one message at a time; the next request transfer can be taken in the
//   same cycle that rsp_tvalid rises. Each scan walks one memory entry per cycle.
// Reset: synchronous; a clearing pass over CLEAR_LEN (1024) addresses zeroes both tables.
// ----------------------------------------------------------------------------
`default_nettype none

module order_book_by_order_top
   import obbo_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request: tuser = req_type[1:0]
   // tdata = id[31:0], price[63:32], quantity[95:64], side[96], zero pad
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic [1:0]            req_tuser,
   // response: tuser = status[1:0]
   // tdata = bid_valid[0], bid_price[32:1], bid_quantity[64:33],
   //   bid_orders[75:65], ask_valid[76], ask_price[108:77],
   //   ask_quantity[140:109], ask_orders[151:141]
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic [1:0]                 rsp_tuser
);

   // ---------------------------------------------------------------------
   // Table memories
   // ---------------------------------------------------------------------
   logic                o_we;
   logic [ORDER_AW-1:0] o_waddr;
   order_entry_type     o_wdata;
   logic [ORDER_AW-1:0] o_raddr;
   logic [ORDER_W-1:0]  o_rdata;
   order_entry_type     orow;

   logic                l_we;
   logic [LEVEL_AW-1:0] l_waddr;
   level_entry_type     l_wdata;
   logic [LEVEL_AW-1:0] l_raddr;
   logic [LEVEL_W-1:0]  l_rdata;
   level_entry_type     lrow;

   obbo_ram #(.WIDTH(ORDER_W), .DEPTH(ORDER_SLOTS)) u_order_ram (
      .clock (clock),
      .we    (o_we),
      .waddr (o_waddr),
      .wdata (o_wdata),
      .raddr (o_raddr),
      .rdata (o_rdata)
   );

   obbo_ram #(.WIDTH(LEVEL_W), .DEPTH(LEVEL_SLOTS)) u_level_ram (
      .clock (clock),
      .we    (l_we),
      .waddr (l_waddr),
      .wdata (l_wdata),
      .raddr (l_raddr),
      .rdata (l_rdata)
   );

   assign orow = order_entry_type'(o_rdata);
   assign lrow = level_entry_type'(l_rdata);

   // ---------------------------------------------------------------------
   // Control and working registers
   // ---------------------------------------------------------------------
   state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;     // scan / clear address
   logic [CNT_W-1:0] idx_d_ff, idx_d_in; // address of data now on rdata
   logic             pend_ff, pend_in;   // rdata holds a scanned entry

   // captured message
   kind_type         kind_ff, kind_in;
   logic [ID_W-1:0]  id_ff, id_in;
   logic [PX_W-1:0]  px_ff, px_in;
   logic [QTY_W-1:0] qty_ff, qty_in;
   logic             sell_ff, sell_in;

   // order scan results
   logic                ofound_ff, ofound_in;
   logic [ORDER_AW-1:0] oidx_ff, oidx_in;
   order_entry_type     odata_ff, odata_in;
   logic                ofree_ff, ofree_in;
   logic [ORDER_AW-1:0] ofree_idx_ff, ofree_idx_in;

   // level scan key and results
   logic [PX_W-1:0]     lkey_px_ff, lkey_px_in;
   logic                lkey_sell_ff, lkey_sell_in;
   logic                lfound_ff, lfound_in;
   logic [LEVEL_AW-1:0] lidx_ff, lidx_in;
   level_entry_type     ldata_ff, ldata_in;
   logic                lfree_ff, lfree_in;
   logic [LEVEL_AW-1:0] lfree_idx_ff, lfree_idx_in;

   status_type status_ff, status_in;

   // best levels, kept between messages (cleared in apply, rebuilt by the rescan)
   logic               bid_ok_ff, bid_ok_in;
   logic [PX_W-1:0]    bid_px_ff, bid_px_in;
   logic [QTY_W-1:0]   bid_tot_ff, bid_tot_in;
   logic [COUNT_W-1:0] bid_cnt_ff, bid_cnt_in;
   logic               ask_ok_ff, ask_ok_in;
   logic [PX_W-1:0]    ask_px_ff, ask_px_in;
   logic [QTY_W-1:0]   ask_tot_ff, ask_tot_in;
   logic [COUNT_W-1:0] ask_cnt_ff, ask_cnt_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   status_type            rsp_status_ff, rsp_status_in;

   // apply-step arithmetic
   logic [QTY_W-1:0]   trade_q;
   logic [QTY_W-1:0]   rem_left;
   logic [COUNT_W-1:0] cnt_dec;

   always_comb begin
      trade_q  = (qty_ff < odata_ff.remaining) ? qty_ff : odata_ff.remaining;
      rem_left = odata_ff.remaining - trade_q;
      cnt_dec  = (ldata_ff.count != '0) ? ldata_ff.count - COUNT_W'(1) : '0;
   end

   // ---------------------------------------------------------------------
   // Next state and datapath
   // ---------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      idx_d_in     = cnt_ff;
      pend_in      = 1'b0;
      kind_in      = kind_ff;
      id_in        = id_ff;
      px_in        = px_ff;
      qty_in       = qty_ff;
      sell_in      = sell_ff;
      ofound_in    = ofound_ff;
      oidx_in      = oidx_ff;
      odata_in     = odata_ff;
      ofree_in     = ofree_ff;
      ofree_idx_in = ofree_idx_ff;
      lkey_px_in   = lkey_px_ff;
      lkey_sell_in = lkey_sell_ff;
      lfound_in    = lfound_ff;
      lidx_in      = lidx_ff;
      ldata_in     = ldata_ff;
      lfree_in     = lfree_ff;
      lfree_idx_in = lfree_idx_ff;
      status_in    = status_ff;
      bid_ok_in    = bid_ok_ff;
      bid_px_in    = bid_px_ff;
      bid_tot_in   = bid_tot_ff;
      bid_cnt_in   = bid_cnt_ff;
      ask_ok_in    = ask_ok_ff;
      ask_px_in    = ask_px_ff;
      ask_tot_in   = ask_tot_ff;
      ask_cnt_in   = ask_cnt_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;

      o_we    = 1'b0;
      o_waddr = cnt_ff[ORDER_AW-1:0];
      o_wdata = '0;
      o_raddr = cnt_ff[ORDER_AW-1:0];
      l_we    = 1'b0;
      l_waddr = cnt_ff[LEVEL_AW-1:0];
      l_wdata = '0;
      l_raddr = cnt_ff[LEVEL_AW-1:0];

      req_tready = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            // zero every entry so that all valid bits start low
            o_we = (cnt_ff < CNT_W'(ORDER_SLOTS));
            l_we = (cnt_ff < CNT_W'(LEVEL_SLOTS));
            if (cnt_ff == CNT_W'(CLEAR_LEN - 1)) begin
               state_in = ST_IDLE;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end

         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               kind_in   = kind_type'(req_tuser);
               id_in     = req_tdata[31:0];
               px_in     = req_tdata[63:32];
               qty_in    = req_tdata[95:64];
               sell_in   = req_tdata[96];
               ofound_in = 1'b0;
               ofree_in  = 1'b0;
               cnt_in    = '0;
               state_in  = ST_OSCAN;
            end
         end

         ST_OSCAN: begin
            if (pend_ff) begin
               if (!ofound_ff && orow.valid && orow.key == id_ff) begin
                  ofound_in = 1'b1;
                  oidx_in   = idx_d_ff[ORDER_AW-1:0];
                  odata_in  = orow;
               end
               if (!ofree_ff && !orow.valid) begin
                  ofree_in     = 1'b1;
                  ofree_idx_in = idx_d_ff[ORDER_AW-1:0];
               end
            end
            if (cnt_ff != CNT_W'(ORDER_SLOTS)) begin
               pend_in = 1'b1;
               cnt_in  = cnt_ff + CNT_W'(1);
            end else if (!pend_ff) begin
               cnt_in    = '0;
               lfound_in = 1'b0;
               lfree_in  = 1'b0;
               status_in = STAT_APPLIED;
               if (kind_ff == KIND_ADD) begin
                  lkey_px_in   = px_ff;
                  lkey_sell_in = sell_ff;
                  if (ofound_ff) begin
                     status_in = STAT_DUPLICATE;
                     state_in  = ST_DONE;
                  end else if (!ofree_ff) begin
                     status_in = STAT_FULL;
                     state_in  = ST_DONE;
                  end else begin
                     state_in = ST_LSCAN;
                  end
               end else begin
                  lkey_px_in   = odata_ff.price;
                  lkey_sell_in = odata_ff.sell;
                  if (!ofound_ff) begin
                     status_in = STAT_UNKNOWN;
                     state_in  = ST_DONE;
                  end else begin
                     state_in = ST_LSCAN;
                  end
               end
            end
         end

         ST_LSCAN: begin
            if (pend_ff) begin
               if (!lfound_ff && lrow.valid && lrow.price == lkey_px_ff &&
                   lrow.sell == lkey_sell_ff) begin
                  lfound_in = 1'b1;
                  lidx_in   = idx_d_ff[LEVEL_AW-1:0];
                  ldata_in  = lrow;
               end
               if (!lfree_ff && !lrow.valid) begin
                  lfree_in     = 1'b1;
                  lfree_idx_in = idx_d_ff[LEVEL_AW-1:0];
               end
            end
            if (cnt_ff != CNT_W'(LEVEL_SLOTS)) begin
               pend_in = 1'b1;
               cnt_in  = cnt_ff + CNT_W'(1);
            end else if (!pend_ff) begin
               cnt_in = '0;
               if (kind_ff == KIND_ADD && !lfound_ff && !lfree_ff) begin
                  status_in = STAT_FULL;
                  state_in  = ST_DONE;
               end else begin
                  state_in = ST_APPLY;
               end
            end
         end

         ST_APPLY: begin
            o_waddr = oidx_ff;
            l_waddr = lidx_ff;
            l_wdata = ldata_ff;
            o_wdata = odata_ff;
            case (kind_ff)
               KIND_ADD: begin
                  o_we    = 1'b1;
                  o_waddr = ofree_idx_ff;
                  o_wdata = '{valid: 1'b1, sell: sell_ff, key: id_ff,
                              price: px_ff, remaining: qty_ff};
                  l_we    = 1'b1;
                  if (lfound_ff) begin
                     l_wdata.total = ldata_ff.total + qty_ff;
                     l_wdata.count = ldata_ff.count + COUNT_W'(1);
                  end else begin
                     l_waddr = lfree_idx_ff;
                     l_wdata = '{valid: 1'b1, sell: sell_ff, price: px_ff,
                                 total: qty_ff, count: COUNT_W'(1)};
                  end
               end
               KIND_MODIFY: begin
                  o_we              = 1'b1;
                  o_wdata.remaining = qty_ff;
                  l_we              = lfound_ff;
                  l_wdata.total     = ldata_ff.total - odata_ff.remaining + qty_ff;
               end
               KIND_CANCEL: begin
                  o_we          = 1'b1;
                  o_wdata.valid = 1'b0;
                  l_we          = lfound_ff;
                  l_wdata.total = ldata_ff.total - odata_ff.remaining;
                  l_wdata.count = cnt_dec;
                  l_wdata.valid = (cnt_dec != '0);
               end
               KIND_TRADE: begin
                  o_we              = 1'b1;
                  o_wdata.remaining = rem_left;
                  l_we              = lfound_ff;
                  l_wdata.total     = ldata_ff.total - trade_q;
                  if (rem_left == '0) begin
                     // fully executed: order leaves the book
                     o_wdata.valid = 1'b0;
                     l_wdata.count = cnt_dec;
                     l_wdata.valid = (cnt_dec != '0);
                  end
               end
               default: begin
                  o_we = 1'b0;
               end
            endcase
            bid_ok_in  = 1'b0;
            bid_px_in  = '0;
            bid_tot_in = '0;
            bid_cnt_in = '0;
            ask_ok_in  = 1'b0;
            ask_px_in  = '0;
            ask_tot_in = '0;
            ask_cnt_in = '0;
            cnt_in     = '0;
            state_in   = ST_RSCAN;
         end

         ST_RSCAN: begin
            if (pend_ff && lrow.valid) begin
               if (!lrow.sell && (!bid_ok_ff || lrow.price > bid_px_ff)) begin
                  bid_ok_in  = 1'b1;
                  bid_px_in  = lrow.price;
                  bid_tot_in = lrow.total;
                  bid_cnt_in = lrow.count;
               end
               if (lrow.sell && (!ask_ok_ff || lrow.price < ask_px_ff)) begin
                  ask_ok_in  = 1'b1;
                  ask_px_in  = lrow.price;
                  ask_tot_in = lrow.total;
                  ask_cnt_in = lrow.count;
               end
            end
            if (cnt_ff != CNT_W'(LEVEL_SLOTS)) begin
               pend_in = 1'b1;
               cnt_in  = cnt_ff + CNT_W'(1);
            end else if (!pend_ff) begin
               cnt_in   = '0;
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_data_in   = {ask_cnt_ff, ask_tot_ff, ask_px_ff, ask_ok_ff,
                                bid_cnt_ff, bid_tot_ff, bid_px_ff, bid_ok_ff};
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         bid_ok_ff    <= 1'b0;
         bid_px_ff    <= '0;
         bid_tot_ff   <= '0;
         bid_cnt_ff   <= '0;
         ask_ok_ff    <= 1'b0;
         ask_px_ff    <= '0;
         ask_tot_ff   <= '0;
         ask_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         bid_ok_ff    <= bid_ok_in;
         bid_px_ff    <= bid_px_in;
         bid_tot_ff   <= bid_tot_in;
         bid_cnt_ff   <= bid_cnt_in;
         ask_ok_ff    <= ask_ok_in;
         ask_px_ff    <= ask_px_in;
         ask_tot_ff   <= ask_tot_in;
         ask_cnt_ff   <= ask_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_d_ff      <= idx_d_in;
      kind_ff       <= kind_in;
      id_ff         <= id_in;
      px_ff         <= px_in;
      qty_ff        <= qty_in;
      sell_ff       <= sell_in;
      ofound_ff     <= ofound_in;
      oidx_ff       <= oidx_in;
      odata_ff      <= odata_in;
      ofree_ff      <= ofree_in;
      ofree_idx_ff  <= ofree_idx_in;
      lkey_px_ff    <= lkey_px_in;
      lkey_sell_ff  <= lkey_sell_in;
      lfound_ff     <= lfound_in;
      lidx_ff       <= lidx_in;
      ldata_ff      <= ldata_in;
      lfree_ff      <= lfree_in;
      lfree_idx_ff  <= lfree_idx_in;
      status_ff     <= status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/obbo_ram.sv =====
// ----------------------------------------------------------------------------
// obbo_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module obbo_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire
